[hw/rtl/bia_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bia_pkg: shared constants and types of the bitmap ID allocator
// Geometry of the used map, command codes and the command/status bundles
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package bia_pkg;

    // Map geometry (both counts are powers of two)
    localparam int TABLE_WORDS = 2048;
    localparam int WORD_BITS   = 32;
    localparam int ID_W        = 16;
    localparam int CMD_W       = 3;

    localparam int ID_SPACE   = 1 << ID_W;
    localparam int MAP_BITS   = TABLE_WORDS * WORD_BITS;
    localparam int CAPACITY   = (MAP_BITS < ID_SPACE) ? MAP_BITS : ID_SPACE;
    localparam int ADDR_W     = $clog2(TABLE_WORDS);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int SCAN_WORDS = CAPACITY / WORD_BITS;
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FREE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MARK  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY = 3'd4;

    // Status codes
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

    typedef logic [WORD_BITS-1:0] word_t;

    // Controller to datapath
    typedef struct packed {
        logic load;        // latch the incoming word
        logic sweep_init;  // start a clearing pass
        logic sweep_step;  // write one zero word
        logic rd_start;    // first map read of a command
        logic scan_next;   // step the scan to the next word and read it
        logic alloc_wr;    // set the found bit and update pointer
        logic upd;         // finish free, mark or query
        logic res_full;    // result: map full
        logic res_clear;   // result: clear done
        logic res_miss;    // result: id outside the map
        logic out_load;    // move result into the output register
    } bia_ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic op_clear;
        logic op_alloc;
        logic full;
        logic id_in_map;
        logic scan_hit;
        logic sweep_last;
        logic out_free;
    } bia_sts_t;

endpackage
`default_nettype wire

[hw/rtl/bia_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bia_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[hw/rtl/bia_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bia_ctrl: command sequencer of the bitmap ID allocator
// Walks each command through decode, map access and result hand-off, and
// runs the clearing pass after reset and on a clear command.
// ----------------------------------------------------------------------------
module bia_ctrl
    import bia_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire bia_sts_t sts,
    output bia_ctl_t      ctl
);

    localparam logic [2:0] S_SWEEP  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECODE = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_RMW    = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       reply_reg, reply_next;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        reply_next = reply_reg;
        ctl        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_SWEEP:
            begin
                ctl.sweep_step = 1'b1;
                if (sts.sweep_last)
                begin
                    reply_next = 1'b0;
                    if (reply_reg)
                    begin
                        ctl.res_clear = 1'b1;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.op_clear)
                begin
                    ctl.sweep_init = 1'b1;
                    reply_next     = 1'b1;
                    state_next     = S_SWEEP;
                end
                else if (sts.op_alloc)
                begin
                    if (sts.full)
                    begin
                        ctl.res_full = 1'b1;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        ctl.rd_start = 1'b1;
                        state_next   = S_SCAN;
                    end
                end
                else if (sts.id_in_map)
                begin
                    ctl.rd_start = 1'b1;
                    state_next   = S_RMW;
                end
                else
                begin
                    ctl.res_miss = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_hit)
                begin
                    ctl.alloc_wr = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    ctl.scan_next = 1'b1;
                end
            end
            S_RMW:
            begin
                ctl.upd    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers: start with a clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SWEEP;
            reply_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            reply_reg <= reply_next;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/bia_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bia_dp: datapath of the bitmap ID allocator
// Holds the used map RAM, allocation pointer, used count, scan window,
// result staging and the output register.
// ----------------------------------------------------------------------------
module bia_dp
    import bia_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [CMD_W-1:0] cmd,
    input  wire logic [ID_W-1:0]  id,
    output logic                  rsp_valid,
    input  wire logic             rsp_ready,
    output logic      [ID_W-1:0]  id_out,
    output logic                  in_use,
    output logic                  status,
    input  wire bia_ctl_t         ctl,
    output bia_sts_t              sts
);

    localparam logic [ID_W:0]     CAP_ID    = (ID_W + 1)'(CAPACITY);
    localparam logic [CNT_W-1:0]  CAP_CNT   = CNT_W'(CAPACITY);
    localparam logic [ADDR_W-1:0] SCAN_LAST = ADDR_W'(SCAN_WORDS - 1);
    localparam logic [ADDR_W-1:0] SWEEP_END = ADDR_W'(TABLE_WORDS - 1);

    // Lowest clear bit of a word
    function automatic logic [BIT_W-1:0] low_zero(input word_t w);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

    logic [CMD_W-1:0]  cmd_reg;
    logic [ID_W-1:0]   id_reg;
    logic [ID_W-1:0]   ptr_reg, ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;
    logic [ADDR_W-1:0] scan_word_reg;
    word_t             scan_mask_reg;
    logic [ID_W-1:0]   res_id_reg;
    logic              res_in_use_reg;
    logic              res_status_reg;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [ID_W-1:0]   id_out_reg;
    logic              in_use_reg;
    logic              status_reg;

    logic              op_clear, op_alloc, op_free, op_mark, op_write;
    logic [ID_W-1:0]   start_id;
    logic              start_in_map;
    logic [ADDR_W-1:0] id_word;
    logic [BIT_W-1:0]  id_bit;
    logic [ADDR_W-1:0] scan_word_inc;
    word_t             rdata;
    word_t             scan_view;
    logic              scan_hit;
    logic [BIT_W-1:0]  hit_bit;
    logic [ID_W-1:0]   new_id;
    word_t             id_onehot;
    logic              old_bit;
    logic              out_free;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    word_t             ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;

    // Decode the latched command
    assign op_clear = (cmd_reg == CMD_CLEAR);
    assign op_alloc = (cmd_reg == CMD_ALLOC);
    assign op_free  = (cmd_reg == CMD_FREE);
    assign op_mark  = (cmd_reg == CMD_MARK);
    assign op_write = op_free || op_mark;

    // Address arithmetic
    assign start_id      = ptr_reg + ID_W'(1);
    assign start_in_map  = {1'b0, start_id} < CAP_ID;
    assign id_word       = ADDR_W'(id_reg >> BIT_W);
    assign id_bit        = id_reg[BIT_W-1:0];
    assign id_onehot     = word_t'(1) << id_bit;
    assign scan_word_inc = (scan_word_reg == SCAN_LAST) ? '0 : scan_word_reg + ADDR_W'(1);

    // Search the word just read
    assign scan_view = rdata | ~scan_mask_reg;
    assign scan_hit  = ~&scan_view;
    assign hit_bit   = low_zero(scan_view);
    assign new_id    = ID_W'({scan_word_reg, hit_bit});
    assign old_bit   = rdata[id_bit];

    assign out_free  = !rsp_valid_reg || rsp_ready;

    // Map RAM ports
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = id_word;
        ram_wdata = rdata | id_onehot;
        if (ctl.sweep_step)
        begin
            ram_we    = 1'b1;
            ram_waddr = sweep_reg;
            ram_wdata = (sweep_reg == '0) ? word_t'(1) : '0;
        end
        else if (ctl.alloc_wr)
        begin
            ram_we    = 1'b1;
            ram_waddr = scan_word_reg;
            ram_wdata = rdata | (word_t'(1) << hit_bit);
        end
        else if (ctl.upd && op_write)
        begin
            ram_we    = 1'b1;
            ram_wdata = op_free ? (rdata & ~id_onehot) : (rdata | id_onehot);
        end
    end

    assign ram_re    = ctl.rd_start || ctl.scan_next;
    assign ram_raddr = ctl.scan_next ? scan_word_inc : (op_alloc ? scan_word_reg : id_word);

    bia_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (TABLE_WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    // Pointer, used count and sweep counter
    always_comb
    begin
        ptr_next   = ptr_reg;
        count_next = count_reg;
        sweep_next = sweep_reg;
        if (ctl.sweep_init)
        begin
            sweep_next = '0;
            count_next = CNT_W'(1);
        end
        else if (ctl.sweep_step)
        begin
            sweep_next = (sweep_reg == SWEEP_END) ? '0 : sweep_reg + ADDR_W'(1);
        end
        if (ctl.alloc_wr)
        begin
            ptr_next   = new_id;
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctl.upd && op_free)
        begin
            count_next = count_reg - CNT_W'(old_bit);
        end
        else if (ctl.upd && op_mark)
        begin
            count_next = count_reg + CNT_W'(!old_bit);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg   <= '0;
            count_reg <= CNT_W'(1);
            sweep_reg <= '0;
        end
        else
        begin
            ptr_reg   <= ptr_next;
            count_reg <= count_next;
            sweep_reg <= sweep_next;
        end
    end

    // Latch the command word and set up the scan window
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= cmd;
            id_reg  <= id;
            if (start_in_map)
            begin
                scan_word_reg <= ADDR_W'(start_id >> BIT_W);
                scan_mask_reg <= {WORD_BITS{1'b1}} << start_id[BIT_W-1:0];
            end
            else
            begin
                scan_word_reg <= '0;
                scan_mask_reg <= '1;
            end
        end
        else if (ctl.scan_next)
        begin
            scan_word_reg <= scan_word_inc;
            scan_mask_reg <= '1;
        end
    end

    // Stage the result
    always_ff @(posedge clk)
    begin
        if (ctl.res_full)
        begin
            res_id_reg     <= ptr_reg;
            res_in_use_reg <= 1'b1;
            res_status_reg <= ST_FULL;
        end
        else if (ctl.res_clear)
        begin
            res_id_reg     <= '0;
            res_in_use_reg <= 1'b1;
            res_status_reg <= ST_OK;
        end
        else if (ctl.res_miss)
        begin
            res_id_reg     <= id_reg;
            res_in_use_reg <= 1'b1;
            res_status_reg <= ST_OK;
        end
        else if (ctl.alloc_wr)
        begin
            res_id_reg     <= new_id;
            res_in_use_reg <= 1'b1;
            res_status_reg <= ST_OK;
        end
        else if (ctl.upd)
        begin
            res_id_reg     <= id_reg;
            res_in_use_reg <= op_free ? 1'b0 : (op_mark ? 1'b1 : old_bit);
            res_status_reg <= ST_OK;
        end
    end

    // Output register
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (ctl.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            id_out_reg <= res_id_reg;
            in_use_reg <= res_in_use_reg;
            status_reg <= res_status_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign id_out    = id_out_reg;
    assign in_use    = in_use_reg;
    assign status    = status_reg;

    // Status to the controller
    assign sts.op_clear   = op_clear;
    assign sts.op_alloc   = op_alloc;
    assign sts.full       = (count_reg >= CAP_CNT);
    assign sts.id_in_map  = {1'b0, id_reg} < CAP_ID;
    assign sts.scan_hit   = scan_hit;
    assign sts.sweep_last = (sweep_reg == SWEEP_END);
    assign sts.out_free   = out_free;

    // Used count never passes the number of identifiers in the map
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("used count above capacity");

    // An allocation write only follows a word with a free bit
    a_alloc_hit: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.alloc_wr |-> scan_hit)
        else $error("allocation write without a free bit");

    // A new result never overwrites one that is still waiting
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> out_free)
        else $error("output register overwritten");

    // An allocated identifier is reported as used
    a_alloc_used: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.alloc_wr |=> (res_in_use_reg && res_status_reg == ST_OK))
        else $error("allocated id not reported used");

    // Read-modify-write finishes only single-bit commands
    a_upd_op: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.upd |-> (!op_clear && !op_alloc))
        else $error("update step on clear or allocate");

endmodule
`default_nettype wire

[hw/rtl/bitmap_id_allocator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_id_allocator: next-fit allocator of 16-bit identifiers
// Keeps a used bit per identifier in a word RAM, a rotating allocation
// pointer and a used count that flags a full map at once.
//
//   channel  | handshake              | words
//   ---------+------------------------+-------------------------
//   request  | req_valid / req_ready  | cmd, id
//   response | rsp_valid / rsp_ready  | id_out, in_use, status
//
// Free, mark used and query step through decode, a read-modify-write state
// and done; a full allocate goes from decode straight to done; allocate
// scans, reading one RAM word per cycle from the word of pointer+1. After
// reset, and for a clear, a pass writes all 2048 map words, one per cycle;
// a clear answers after the pass and no request is accepted meanwhile.
// The next request is taken once the result has moved to the response
// register. One command is in flight at a time; a waiting response does not
// block the next request, it stalls only the hand-off of the following result.
// ----------------------------------------------------------------------------
module bitmap_id_allocator
    import bia_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_ready,
    input  wire logic [CMD_W-1:0] cmd,
    input  wire logic [ID_W-1:0]  id,
    output logic                  rsp_valid,
    input  wire logic             rsp_ready,
    output logic      [ID_W-1:0]  id_out,
    output logic                  in_use,
    output logic                  status
);

    bia_ctl_t ctl;
    bia_sts_t sts;

    bia_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    bia_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .id        (id),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .id_out    (id_out),
        .in_use    (in_use),
        .status    (status),
        .ctl       (ctl),
        .sts       (sts)
    );

endmodule
`default_nettype wire

[tb/sv/bitmap_id_allocator_tb.sv]
// ----------------------------------------------------------------------------
// bitmap_id_allocator_tb: self-checking bench for the bitmap ID allocator
// Drives clear, allocate, free, mark, query and the spare command codes
// over the request channel. Each accepted word is run through a bit-accurate
// model of the used map and the next-fit pointer, and every response word
// is compared field by field against the oldest predicted reply. The run
// probes zero handling and allocation around freed bits, then runs random
// traffic under three sender/receiver idle mixes with a long receiver hold-off.
// ----------------------------------------------------------------------------
module bitmap_id_allocator_tb
    import bia_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Spare codes behave as query
    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = CMD_QUERY + 1'b1;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = '1;

    // A hang shows up long before this; the limit leaves room for the slowest
    // legal run, with every word a clear or an allocate that scans the whole
    // map
    localparam int unsigned CYCLE_LIMIT  = 10_000_000;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned PHASE_WORDS  = 400;
    localparam int unsigned SETTLE_TICKS = 16;

    typedef struct {
        logic [ID_W-1:0] id_out;
        logic            in_use;
        logic            status;
    } reply_t;

    // ------------------------------------------------------------------------
    // Used map, pointer and the queue of replies still owed by the block
    // ------------------------------------------------------------------------
    class id_map_scoreboard;
        word_t           words [TABLE_WORDS];
        logic [ID_W-1:0] next_ptr;
        int unsigned     used_total;
        reply_t          replies_due [$];
        int unsigned     errors;
        int unsigned     n_alloc, n_full, n_clear, n_change, n_query, n_checked;

        function new();
            clear_map();
            next_ptr = '0;
        endfunction

        // Identifiers with no bit in the map count as used
        function bit bit_used(int unsigned n);
            if (n >= CAPACITY)
                return 1'b1;
            return words[n / WORD_BITS][n % WORD_BITS];
        endfunction

        function void set_bit(int unsigned n, bit v);
            if (n >= CAPACITY)
                return;
            if (v && !bit_used(n))
                used_total++;
            if (!v && bit_used(n))
                used_total--;
            words[n / WORD_BITS][n % WORD_BITS] = v;
        endfunction

        // Free everything, keep identifier zero used
        function void clear_map();
            foreach (words[w])
                words[w] = '0;
            used_total = 0;
            set_bit(0, 1'b1);
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

        // Apply one accepted request word and queue the reply it owes
        function void note_request(logic [CMD_W-1:0] c, logic [ID_W-1:0] n);
            reply_t      r;
            int unsigned p;
            r.id_out = n;
            r.status = ST_OK;
            case (c)
                CMD_CLEAR:
                begin
                    clear_map();
                    r.id_out = '0;
                    n_clear++;
                end
                CMD_ALLOC:
                begin
                    n_alloc++;
                    if (used_total >= CAPACITY)
                    begin
                        r.id_out = next_ptr;
                        r.status = ST_FULL;
                        n_full++;
                    end
                    else
                    begin
                        // Search from pointer+1, hop over fully used words
                        p = next_ptr;
                        do
                        begin
                            p = (p + 1) % ID_SPACE;
                            if (p < CAPACITY && p % WORD_BITS == 0 && &words[p / WORD_BITS])
                                p = (p + WORD_BITS - 1) % ID_SPACE;
                        end
                        while (bit_used(p));
                        set_bit(p, 1'b1);
                        next_ptr = p[ID_W-1:0];
                        r.id_out = p[ID_W-1:0];
                    end
                end
                CMD_FREE:
                begin
                    set_bit(n, 1'b0);
                    n_change++;
                end
                CMD_MARK:
                begin
                    set_bit(n, 1'b1);
                    n_change++;
                end
                default:
                    n_query++;
            endcase
            r.in_use = bit_used(r.id_out);
            replies_due.push_back(r);
        endfunction

        // Compare one response word against the oldest owed reply
        function void check_reply(logic [ID_W-1:0] got_id, logic got_use, logic got_st);
            reply_t exp_r;
            if (replies_due.size() == 0)
            begin
                $display("%0t: unexpected response id_out=%0d in_use=%0b status=%0b",
                         $time, got_id, got_use, got_st);
                errors++;
                return;
            end
            exp_r = replies_due.pop_front();
            n_checked++;
            if (got_id !== exp_r.id_out)
            begin
                $display("%0t: id_out expected %0d, got %0d", $time, exp_r.id_out, got_id);
                errors++;
            end
            if (got_use !== exp_r.in_use)
            begin
                $display("%0t: in_use expected %0b, got %0b (id_out %0d)",
                         $time, exp_r.in_use, got_use, exp_r.id_out);
                errors++;
            end
            if (got_st !== exp_r.status)
            begin
                $display("%0t: status expected %0b, got %0b (id_out %0d)",
                         $time, exp_r.status, got_st, exp_r.id_out);
                errors++;
            end
        endfunction
    endclass

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             req_valid = 1'b0;
    logic             req_ready;
    logic [CMD_W-1:0] cmd       = CMD_QUERY;
    logic [ID_W-1:0]  id        = '0;
    logic             rsp_valid;
    logic             rsp_ready = 1'b0;
    logic [ID_W-1:0]  id_out;
    logic             in_use;
    logic             status;

    id_map_scoreboard sb;
    int unsigned      send_idle_pct = 0;
    int unsigned      recv_idle_pct = 0;
    int unsigned      hold_asks     = 0;
    int unsigned      words_sent    = 0;
    int unsigned      cycle_count   = 0;

    bitmap_id_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .cmd       (cmd),
        .id        (id),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .id_out    (id_out),
        .in_use    (in_use),
        .status    (status)
    );

    always #5 clk = ~clk;

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d replies owed", cycle_count, sb.pending());
            $display("simulation failed");
            $finish;
        end
    end

    function automatic bit roll(int unsigned pct);
        return $urandom_range(99) < pct;
    endfunction

    // Response side: check accepted words, then pick the next ready level
    initial
    begin
        int unsigned hold_seen;
        int unsigned hold_left;
        hold_seen = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && rsp_ready)
                sb.check_reply(id_out, in_use, status);
            if (hold_asks != hold_seen)
            begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= !roll(recv_idle_pct);
        end
    end

    // Offer one request word, with a random gap first, and hold it until taken
    task automatic issue(logic [CMD_W-1:0] c, logic [ID_W-1:0] n);
        if (roll(send_idle_pct))
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while (roll(send_idle_pct));
        end
        req_valid <= 1'b1;
        cmd       <= c;
        id        <= n;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sb.note_request(c, n);
        words_sent++;
    endtask

    // Drop valid and hold until every owed reply has come back
    task automatic wait_drained();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // Half of the ids around the pointer, where used and free bits mix
    function automatic logic [ID_W-1:0] pick_id();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 50)
            return sb.next_ptr - 16'd96 + 16'($urandom_range(127));
        if (r < 60)
        begin
            case ($urandom_range(3))
                0: return '0;
                1: return '1;
                2: return 16'(WORD_BITS);
                default: return 16'(WORD_BITS - 1);
            endcase
        end
        return 16'($urandom);
    endfunction

    // One random step: a single command, or a word-fill run ending in allocate
    task automatic random_step();
        int unsigned r;
        int unsigned w;
        r = $urandom_range(999);
        if (r < 10)
            issue(CMD_CLEAR, 16'($urandom));
        else if (r < 360)
            issue(CMD_ALLOC, 16'($urandom));
        else if (r < 560)
            issue(CMD_FREE, pick_id());
        else if (r < 700)
            issue(CMD_MARK, pick_id());
        else if (r < 900)
            issue(CMD_QUERY, pick_id());
        else if (r < 965)
            issue(3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST)), pick_id());
        else
        begin
            // Fill the word after the pointer's word so the scan must skip it
            w = (sb.next_ptr / WORD_BITS + 1) % SCAN_WORDS;
            for (int b = 0; b < WORD_BITS; b++)
                issue(CMD_MARK, 16'(w * WORD_BITS + b));
            issue(CMD_ALLOC, 16'($urandom));
        end
    endtask

    task automatic random_phase(int unsigned s_pct, int unsigned r_pct, bit with_hold);
        int unsigned start;
        bit          held;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        start         = words_sent;
        held          = 1'b0;
        while (words_sent - start < PHASE_WORDS)
        begin
            random_step();
            // Stall the response side for a long stretch while requests keep coming
            if (with_hold && !held && words_sent - start >= PHASE_WORDS / 4)
            begin
                held      = 1'b1;
                hold_asks <= hold_asks + 1;
            end
        end
        wait_drained();
    endtask

    initial
    begin
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset state, zero handling, extremes, spare codes
        issue(CMD_QUERY, 16'h0000);
        issue(CMD_QUERY, 16'hFFFF);
        issue(CMD_SPARE_FIRST, 16'h0000);
        issue(CMD_ALLOC, 16'h0000);
        issue(CMD_ALLOC, 16'hFFFF);
        issue(CMD_MARK, 16'hFFFF);
        issue(CMD_SPARE_LAST, 16'hFFFF);
        issue(CMD_MARK, 16'h0002);
        issue(CMD_FREE, 16'h0028);
        issue(CMD_FREE, 16'h0001);
        issue(CMD_SPARE_FIRST + 1'b1, 16'h0001);
        issue(CMD_FREE, 16'hFFFF);
        issue(CMD_FREE, 16'h0000);
        issue(CMD_QUERY, 16'h0000);
        issue(CMD_MARK, 16'hAAAA);
        issue(CMD_MARK, 16'h5555);
        issue(CMD_QUERY, 16'h5555);
        issue(CMD_ALLOC, 16'h5555);
        issue(CMD_CLEAR, 16'hAAAA);
        issue(CMD_QUERY, 16'hAAAA);
        issue(CMD_QUERY, 16'h0000);
        issue(CMD_ALLOC, 16'h0000);
        wait_drained();

        // Allocate around freed bits, zero and a far identifier
        issue(CMD_CLEAR, 16'h0000);
        issue(CMD_ALLOC, 16'h0000);
        issue(CMD_FREE, sb.next_ptr);
        issue(CMD_ALLOC, 16'h0000);
        issue(CMD_ALLOC, 16'h0000);
        issue(CMD_FREE, 16'h0000);
        issue(CMD_ALLOC, 16'h0000);
        issue(CMD_FREE, 16'd100);
        issue(CMD_FREE, 16'd40000);
        issue(CMD_ALLOC, 16'h0000);
        issue(CMD_ALLOC, 16'h0000);
        issue(CMD_FREE, 16'd3);
        issue(CMD_ALLOC, 16'h0000);
        issue(CMD_QUERY, 16'd3);
        issue(CMD_CLEAR, 16'h0000);
        wait_drained();

        // Random traffic under three idle mixes
        random_phase(19, 57, 1'b1);
        random_phase(57, 19, 1'b0);
        random_phase(0, 0, 1'b0);

        wait_drained();
        repeat (SETTLE_TICKS) @(posedge clk);

        $display("run covered %0d request words, %0d replies checked, %0d mismatches",
                 words_sent, sb.n_checked, sb.errors);
        $display("  %0d allocates (%0d on a full map), %0d clears, %0d free/mark, %0d queries",
                 sb.n_alloc, sb.n_full, sb.n_clear, sb.n_change, sb.n_query);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
